/* rtl/axis_contain_clamp_wrap_assert.svh */
// Assertion macros for the axis containment block
`ifndef AXIS_CONTAIN_CLAMP_WRAP_ASSERT_SVH
`define AXIS_CONTAIN_CLAMP_WRAP_ASSERT_SVH

// Implication checked at every rising clock edge outside reset
`define ACC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that holds at every rising clock edge outside reset
`define ACC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

`endif

/* rtl/acc_pkg.sv */
package acc_pkg;

  // Periodic modes
  typedef enum logic [1:0] {
    WRAP_NONE   = 2'd0,
    WRAP_CYCLIC = 2'd1,
    WRAP_MIRROR = 2'd2,
    WRAP_POLAR  = 2'd3
  } wrap_mode_e;

  // Register indexes
  typedef enum logic [2:0] {
    REG_RANGE_START = 3'd0,
    REG_RANGE_END   = 3'd1,
    REG_START_INCL  = 3'd2,
    REG_END_INCL    = 3'd3,
    REG_WRAP_MODE   = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned DivSteps = 33;  // bits of |coordinate - start|
  localparam int unsigned PhSteps  = 16;  // phase bits

  // Side data carried through the modulo divider
  typedef struct packed {
    logic              contained;
    logic [CoordW-1:0] clamp;
    logic [CoordW-1:0] coord;
    logic              neg;
  } side1_t;

  // Side data carried through the phase divider
  typedef struct packed {
    logic              contained;
    logic [CoordW-1:0] clamp;
    logic [CoordW-1:0] coord;
    logic [CoordW-1:0] m;
    logic              par;
  } side2_t;

  // Quarter-wave cosine, cos(k*pi/32) in Q1.16
  function automatic logic [16:0] cos_quarter(input logic [4:0] k);
    logic [16:0] v;
    unique case (k)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd65220;
      5'd2:  v = 17'd64277;
      5'd3:  v = 17'd62714;
      5'd4:  v = 17'd60547;
      5'd5:  v = 17'd57798;
      5'd6:  v = 17'd54491;
      5'd7:  v = 17'd50660;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd41576;
      5'd10: v = 17'd36410;
      5'd11: v = 17'd30893;
      5'd12: v = 17'd25080;
      5'd13: v = 17'd19024;
      5'd14: v = 17'd12785;
      5'd15: v = 17'd6424;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/acc_div_pipe.sv */
module acc_div_pipe #(
  parameter int unsigned STEPS = 16,
  parameter int unsigned SW    = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [31:0]      rem_i,
  input  logic [STEPS-1:0] num_i,
  input  logic [31:0]      div_i,
  input  logic [SW-1:0]    side_i,
  output logic             valid_o,
  output logic [31:0]      rem_o,
  output logic [STEPS-1:0] quot_o,
  output logic [SW-1:0]    side_o
);

  // One restoring step per stage, numerator bits enter MSB first
  logic             valid_q [STEPS];
  logic [31:0]      rem_q   [STEPS];
  logic [STEPS-1:0] num_q   [STEPS];
  logic [STEPS-1:0] quot_q  [STEPS];
  logic [SW-1:0]    side_q  [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic             v_in;
    logic [31:0]      r_in;
    logic [STEPS-1:0] n_in;
    logic [STEPS-1:0] q_in;
    logic [SW-1:0]    s_in;
    logic [32:0]      trial;
    logic [32:0]      diff;
    logic             qbit;

    if (k == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = rem_i;
      assign n_in = num_i;
      assign q_in = '0;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = valid_q[k-1];
      assign r_in = rem_q[k-1];
      assign n_in = num_q[k-1];
      assign q_in = quot_q[k-1];
      assign s_in = side_q[k-1];
    end

    assign trial = {r_in, n_in[STEPS-1]};
    assign diff  = trial - {1'b0, div_i};
    assign qbit  = (trial >= {1'b0, div_i});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= qbit ? diff[31:0] : trial[31:0];
      num_q[k]  <= n_in << 1;
      quot_q[k] <= {q_in[STEPS-2:0], qbit};
      side_q[k] <= s_in;
    end
  end

  assign valid_o = valid_q[STEPS-1];
  assign rem_o   = rem_q[STEPS-1];
  assign quot_o  = quot_q[STEPS-1];
  assign side_o  = side_q[STEPS-1];

endmodule

/* rtl/axis_contain_clamp_wrap.sv */
// Channel    | Ports                                         | Handshake
// config     | cfg_we_i, cfg_idx_i, cfg_data_i               | write when cfg_we_i high
// coordinate | coordinate_i                                  | start high, busy low
// result     | inside_res_o, clamped_value_o, wrapped_value_o | valid_o for one cycle
//
// One word per cycle in, one per cycle out; busy stays low.
// The pipeline runs through an entry register, 33 stages of the modulo divider,
// one fix-up stage, 16 stages of the phase divider, five stages of cosine
// and scaling. Reset clears all valid bits and loads the register defaults.
// The receiver cannot stall, so the pipeline always advances.
module axis_contain_clamp_wrap (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [acc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [acc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                        start,
  output logic                        busy,
  input  logic [acc_pkg::CoordW-1:0]   coordinate_i,
  output logic                        valid_o,
  output logic                        inside_res_o,
  output logic [acc_pkg::CoordW-1:0]   clamped_value_o,
  output logic [acc_pkg::CoordW-1:0]   wrapped_value_o
);
  import acc_pkg::*;

  localparam int unsigned Latency = 1 + DivSteps + 1 + PhSteps + 5;

  // Configuration registers
  logic [31:0] start_q, end_q;
  logic        start_incl_q, end_incl_q;
  wrap_mode_e  mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q      <= 32'd0;
      end_q        <= 32'd65536;
      start_incl_q <= 1'b1;
      end_incl_q   <= 1'b1;
      mode_q       <= WRAP_NONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RANGE_START: start_q      <= cfg_data_i;
        REG_RANGE_END:   end_q        <= cfg_data_i;
        REG_START_INCL:  start_incl_q <= cfg_data_i[0];
        REG_END_INCL:    end_incl_q   <= cfg_data_i[0];
        REG_WRAP_MODE:   mode_q       <= wrap_mode_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  // Range length, positive flag
  logic signed [32:0] rng;
  logic               rng_pos;
  logic [31:0]        rng_u;
  assign rng     = $signed({end_q[31], end_q}) - $signed({start_q[31], start_q});
  assign rng_pos = (rng > 33'sd0);
  assign rng_u   = rng[31:0];

  assign busy = 1'b0;

  // Entry register
  logic        v0_q;
  logic [31:0] p0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
    end
  end
  always_ff @(posedge clk_i) begin
    p0_q <= coordinate_i;
  end

  // Containment, clamp and offset from start
  logic signed [31:0] p_s, s_s, e_s, clamp1, clamp2;
  logic signed [33:0] dlt;
  logic [32:0]        dlt_abs;
  logic               st_ok, en_ok;
  side1_t             side1_in, side1_out;

  always_comb begin
    p_s     = $signed(p0_q);
    s_s     = $signed(start_q);
    e_s     = $signed(end_q);
    st_ok   = start_incl_q ? (p_s >= s_s) : (p_s > s_s);
    en_ok   = end_incl_q ? (p_s <= e_s) : (p_s < e_s);
    clamp1  = (p_s < s_s) ? s_s : p_s;
    clamp2  = (clamp1 > e_s) ? e_s : clamp1;
    dlt     = 34'($signed(p_s)) - 34'($signed(s_s));
    dlt_abs = dlt[33] ? 33'(-dlt) : dlt[32:0];
    side1_in.contained = st_ok && en_ok;
    side1_in.clamp     = clamp2;
    side1_in.coord     = p0_q;
    side1_in.neg       = dlt[33];
  end

  logic              v1;
  logic [31:0]       rem1;
  logic [DivSteps-1:0] quot1;

  acc_div_pipe #(.STEPS(DivSteps), .SW($bits(side1_t))) u_div_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .rem_i   (32'd0),
    .num_i   (dlt_abs),
    .div_i   (rng_u),
    .side_i  (side1_in),
    .valid_o (v1),
    .rem_o   (rem1),
    .quot_o  (quot1),
    .side_o  (side1_out)
  );

  // Floor modulo fix-up for negative offsets
  logic   va_q;
  side2_t sa_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= v1;
    end
  end
  always_ff @(posedge clk_i) begin
    sa_q.contained <= side1_out.contained;
    sa_q.clamp     <= side1_out.clamp;
    sa_q.coord     <= side1_out.coord;
    if (side1_out.neg && (rem1 != 32'd0)) begin
      sa_q.m   <= rng_u - rem1;
      sa_q.par <= ~quot1[0];
    end else begin
      sa_q.m   <= rem1;
      sa_q.par <= quot1[0];
    end
  end

  // Phase = floor(m * 2^16 / r)
  logic               v2;
  logic [31:0]        rem2;
  logic [PhSteps-1:0] ph;
  side2_t             side2_out;

  acc_div_pipe #(.STEPS(PhSteps), .SW($bits(side2_t))) u_div_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (va_q),
    .rem_i   (sa_q.m),
    .num_i   ('0),
    .div_i   (rng_u),
    .side_i  (sa_q),
    .valid_o (v2),
    .rem_o   (rem2),
    .quot_o  (ph),
    .side_o  (side2_out)
  );

  // Quadrant fold and table lookup
  logic [14:0] xq;
  logic [16:0] ta, tb;
  always_comb begin
    xq = ph[14] ? (15'd16384 - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
    ta = cos_quarter({1'b0, xq[13:10]});
    tb = cos_quarter(5'({1'b0, xq[13:10]}) + 5'd1);
  end

  logic        vb_q, vc_q, vd_q, ve_q, vf_q;
  side2_t      sb_q, sc_q, sd_q, se_q;
  logic [16:0] ab_q, ac_q;
  logic [15:0] db_q;
  logic [9:0]  fb_q;
  logic        nb_q, nc_q;
  logic [25:0] prod_c_q;
  logic [17:0] om_d_q;
  logic [49:0] prod_e_q;
  logic        contained_q;
  logic [31:0] clamp_q, wrap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else begin
      vb_q <= v2;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
      vf_q <= ve_q;
    end
  end

  // Interpolation and scaling stages
  logic [16:0] qc;
  logic [31:0] off;
  logic [31:0] w_sel;
  logic [49:0] rnd;
  always_comb begin
    qc  = ac_q - 17'(prod_c_q >> 10);
    rnd = prod_e_q + 50'd65536;
    off = rnd[48:17];
    unique case (mode_q)
      WRAP_NONE:   w_sel = se_q.coord;
      WRAP_CYCLIC: w_sel = start_q + se_q.m;
      WRAP_MIRROR: w_sel = se_q.par ? (end_q - se_q.m) : (start_q + se_q.m);
      WRAP_POLAR:  w_sel = start_q + off;
      default:     w_sel = se_q.coord;
    endcase
    if (!rng_pos) w_sel = se_q.coord;
  end

  always_ff @(posedge clk_i) begin
    // table values
    sb_q <= side2_out;
    nb_q <= ph[15] ^ ph[14];
    fb_q <= xq[9:0];
    if (xq[14]) begin
      ab_q <= 17'd0;
      db_q <= 16'd0;
    end else begin
      ab_q <= ta;
      db_q <= 16'(ta - tb);
    end
    // slope times fraction
    sc_q     <= sb_q;
    ac_q     <= ab_q;
    nc_q     <= nb_q;
    prod_c_q <= db_q * fb_q;
    // one minus cosine
    sd_q   <= sc_q;
    om_d_q <= nc_q ? (18'd65536 + 18'(qc)) : (18'd65536 - 18'(qc));
    // range times one minus cosine
    se_q     <= sd_q;
    prod_e_q <= rng_u * om_d_q;
    // output register
    contained_q <= se_q.contained;
    clamp_q     <= se_q.clamp;
    wrap_q      <= w_sel;
  end

  assign valid_o         = vf_q;
  assign inside_res_o    = contained_q;
  assign clamped_value_o = clamp_q;
  assign wrapped_value_o = wrap_q;

`include "axis_contain_clamp_wrap_assert.svh"

  `ACC_ASSERT_IMP(a_lat, valid_o, $past(start && !busy, Latency), "result without accepted word")
  `ACC_ASSERT_IMP(a_cyc_rng, valid_o && (mode_q == WRAP_CYCLIC) && rng_pos, ($signed(wrapped_value_o) >= $signed(start_q)) && ($signed(wrapped_value_o) < $signed(end_q)), "cyclic wrap out of range")
  `ACC_ASSERT_IMP(a_clamp_rng, valid_o && ($signed(start_q) <= $signed(end_q)), ($signed(clamped_value_o) >= $signed(start_q)) && ($signed(clamped_value_o) <= $signed(end_q)), "clamp out of range")
  `ACC_ASSERT_ALWAYS(a_busy, !busy, "busy raised")

endmodule

/* tb/sv/axis_contain_clamp_wrap_tb.sv */
module axis_contain_clamp_wrap_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import acc_pkg::*;

  localparam int unsigned Latency = 56;
  localparam int unsigned CycleLimit = 400000;

  // Expected result word
  typedef struct packed {
    logic        contained;
    logic [31:0] clamp;
    logic [31:0] wrap;
  } axis_word_t;

  // Quarter-wave cosine table, Q1.16
  function automatic longint qcos(input int unsigned x);
    int unsigned tbl [17] = '{65536, 65220, 64277, 62714, 60547, 57798, 54491, 50660,
                              46341, 41576, 36410, 30893, 25080, 19024, 12785, 6424, 0};
    int unsigned idx, fr, a, b;
    if (x >= 16384) return 0;
    idx = x >> 10;
    fr = x & 1023;
    a = tbl[idx];
    b = tbl[idx + 1];
    return longint'(a - (((a - b) * fr) >> 10));
  endfunction

  function automatic longint phase_cos(input int unsigned ph);
    int unsigned u;
    u = ph & 16383;
    case ((ph >> 14) & 3)
      0: return qcos(u);
      1: return -qcos(16384 - u);
      2: return -qcos(u);
      default: return qcos(16384 - u);
    endcase
  endfunction

  // Predicts containment, clamp and wrap from the current settings
  class axis_scoreboard;
    logic [31:0] lo_end, hi_end;
    logic        lo_closed, hi_closed;
    wrap_mode_e  mode;
    axis_word_t  pending [$];
    int          errors;

    function new();
      lo_end = 0; hi_end = 32'd65536; lo_closed = 1; hi_closed = 1;
      mode = WRAP_NONE; errors = 0;
    endfunction

    function void set_reg(input cfg_idx_e idx, input logic [31:0] v);
      case (idx)
        REG_RANGE_START: lo_end = v;
        REG_RANGE_END:   hi_end = v;
        REG_START_INCL:  lo_closed = v[0];
        REG_END_INCL:    hi_closed = v[0];
        REG_WRAP_MODE:   mode = wrap_mode_e'(v[1:0]);
        default: ;
      endcase
    endfunction

    function void note_coord(input logic [31:0] coord);
      longint p, s, e, r, c, w, d, m, q, cv;
      longint unsigned ph, off;
      axis_word_t x;
      p = longint'($signed(coord));
      s = longint'($signed(lo_end));
      e = longint'($signed(hi_end));
      r = e - s;
      c = p;
      w = p;
      if (c < s) c = s;
      if (c > e) c = e;
      if (mode != WRAP_NONE && r > 0) begin
        d = p - s;
        m = d % r;
        if (m < 0) m += r;
        q = (d - m) / r;
        if (mode == WRAP_CYCLIC) w = s + m;
        else if (mode == WRAP_MIRROR) w = (q[0] == 1'b0) ? s + m : e - m;
        else begin
          ph = (longint'(m) << 16) / r;
          cv = phase_cos(int'(ph & 64'hFFFF));
          off = (longint'(r) * (65536 - cv) + 65536) >> 17;
          w = s + longint'(off);
        end
      end
      x.contained = (lo_closed ? p >= s : p > s) && (hi_closed ? p <= e : p < e);
      x.clamp = c[31:0];
      x.wrap = w[31:0];
      pending.push_back(x);
    endfunction

    function void report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h want %h", what, got, want);
    endfunction

    function void check_word(input logic ins, input logic [31:0] cl, input logic [31:0] wr);
      axis_word_t x;
      if (pending.size() == 0) begin
        report("unexpected word", {31'd0, ins}, 32'd0);
        return;
      end
      x = pending.pop_front();
      if (ins !== x.contained) report("inside", {31'd0, ins}, {31'd0, x.contained});
      if (cl !== x.clamp) report("clamp", cl, x.clamp);
      if (wr !== x.wrap) report("wrap", wr, x.wrap);
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        start = 0;
  logic        busy;
  logic [31:0] coordinate_i = '0;
  logic        valid_o, inside_res_o;
  logic [31:0] clamped_value_o, wrapped_value_o;
  axis_scoreboard sb = new();
  int unsigned cycles = 0;
  int          n_items = 0;

  always #5 clk_i = ~clk_i;

  axis_contain_clamp_wrap dut (.*);

  // Result monitor and watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && valid_o) sb.check_word(inside_res_o, clamped_value_o, wrapped_value_o);
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= v;
    sb.set_reg(cfg_idx_e'(idx), v);
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic set_range(input logic [31:0] s, input logic [31:0] e,
                           input logic si, input logic ei, input wrap_mode_e md);
    write_reg(REG_RANGE_START, s);
    write_reg(REG_RANGE_END, e);
    // upper bits set to show they are dropped
    write_reg(REG_START_INCL, ($urandom & 32'hFFFF_FFFE) | {31'd0, si});
    write_reg(REG_END_INCL, {31'd0, ei});
    write_reg(REG_WRAP_MODE, ($urandom & 32'hFFFF_FFFC) | {30'd0, md});
  endtask

  // Hold start high until the word is taken; random gap afterwards when gaps is set
  task automatic send_coord(input logic [31:0] v, input bit gaps);
    int g;
    start <= 1;
    coordinate_i <= v;
    do @(posedge clk_i); while (busy);
    sb.note_coord(v);
    n_items++;
    g = 0;
    if (gaps) g = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40)
                : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
    if (g > 0) begin
      start <= 0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_coord(input logic [31:0] s, input logic [31:0] e);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return s + $urandom_range(0, 2) - 1;
      2: return e + $urandom_range(0, 2) - 1;
      default: return s + $urandom_range(0, 32'h7FFFF) - 32'h20000;
    endcase
  endfunction

  initial begin
    logic [31:0] s, e, v;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: reset settings, extremes and edge points
    send_coord(32'h8000_0000, 0);
    send_coord(32'h7FFF_FFFF, 0);
    send_coord(32'd0, 0);
    send_coord(32'd65536, 0);
    send_coord(32'hFFFF_FFFF, 0);
    drain();
    // open ends, each periodic mode in turn
    for (int md = 1; md < 4; md++) begin
      set_range(32'hFFFF_0000, 32'h0003_0000, 0, 0, wrap_mode_e'(md));
      send_coord(32'hFFFF_0000, 0);
      send_coord(32'h0003_0000, 0);
      send_coord(32'h0007_8000, 0);
      send_coord(32'hFFF8_1234, 0);
      drain();
    end
    // widest range in polarized mode
    set_range(32'h8000_0000, 32'h7FFF_FFFF, 1, 1, WRAP_POLAR);
    send_coord(32'h8000_0000, 0);
    send_coord(32'h7FFF_FFFF, 0);
    drain();
    // start above end, and empty range
    set_range(32'h0005_0000, 32'h0001_0000, 1, 1, WRAP_MIRROR);
    send_coord(32'h0003_0000, 0);
    send_coord(32'h0009_0000, 0);
    drain();
    write_reg(3'd7, 32'hDEAD_BEEF);  // index out of range, ignored
    send_coord(32'h0000_1000, 0);
    drain();

    // Random phases with fresh settings
    while (n_items < 950) begin
      case ($urandom_range(0, 3))
        0: begin s = $urandom; e = $urandom; end
        1: begin s = $urandom; e = s + $urandom_range(1, 8); end
        default: begin s = $urandom_range(0, 32'h3FFFF) - 32'h20000;
                       e = s + $urandom_range(1, 32'h7FFFF); end
      endcase
      set_range(s, e, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                wrap_mode_e'($urandom_range(0, 3)));
      repeat ($urandom_range(20, 80)) begin
        v = pick_coord(s, e);
        send_coord(v, $urandom_range(0, 4) != 0);
      end
      drain();
    end

    repeat (Latency + 8) @(posedge clk_i);
    $display("Covered %0d coordinates over random ranges, ends and all wrap modes.", n_items);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
